>>> hw/rtl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// PEM bundle checker package
// Shared types, status codes, marker text and per-byte line helpers used by
// the scanner core and the top level.
// ----------------------------------------------------------------------------
package pbc_pkg;

    // Marker and pattern lengths in bytes.
    localparam int BeginLen = 27;
    localparam int EndLen   = 25;
    localparam int KeyLen   = 11;
    localparam int DashLen  = 5;

    // Marker text, first character in the highest byte.
    localparam logic [8*BeginLen-1:0] BeginText = "-----BEGIN CERTIFICATE-----";
    localparam logic [8*EndLen-1:0]   EndText   = "-----END CERTIFICATE-----";
    localparam logic [8*KeyLen-1:0]   KeyText   = "PRIVATE KEY";

    // Special byte values.
    localparam logic [7:0] LfByte     = 8'h0A;
    localparam logic [7:0] CrByte     = 8'h0D;
    localparam logic [7:0] DashByte   = 8'h2D;
    localparam logic [7:0] KeyFirst   = 8'h50;
    localparam logic [7:0] SpaceByte  = 8'h20;
    localparam logic [7:0] DelByte    = 8'h7F;

    // Saturation limits of the byte and line counters.
    localparam logic [10:0] LineSat  = 11'h7FF;
    localparam logic [16:0] TotalSat = 17'h1FFFF;

    // Configuration register reset values.
    localparam logic [15:0] MaxBytesReset = 16'd4096;
    localparam logic [3:0]  MaxCertsReset = 4'd3;
    localparam logic [9:0]  MaxLineReset  = 10'd64;

    // Configuration register indexes (byte address divided by four).
    typedef enum logic [1:0] {
        REG_MAX_BYTES = 2'd0,
        REG_MAX_CERTS = 2'd1,
        REG_MAX_LINE  = 2'd2
    } reg_index_t;

    // Result status codes; STATUS_OK also means no line error recorded.
    typedef enum logic [3:0] {
        STATUS_OK           = 4'd0,
        STATUS_EMPTY        = 4'd1,
        STATUS_TOO_LONG     = 4'd2,
        STATUS_BAD_CHAR     = 4'd3,
        STATUS_NOT_CERT     = 4'd4,
        STATUS_PRIVATE_KEY  = 4'd5,
        STATUS_TOO_MANY     = 4'd6,
        STATUS_BAD_BASE64   = 4'd7,
        STATUS_UNTERMINATED = 4'd8,
        STATUS_NO_CERT      = 4'd9
    } status_t;

    // Configuration values handed to the scanner.
    typedef struct packed {
        logic [15:0] max_bytes;
        logic [3:0]  max_certs;
        logic [9:0]  max_line;
    } cfg_t;

    // One result of a closed bundle.
    typedef struct packed {
        status_t    status;
        logic [3:0] count;
    } result_t;

    // Running state of the current line.
    typedef struct packed {
        logic [10:0] len;
        logic        f_begin;
        logic        f_end;
        logic        f_dash;
        logic        f_b64;
    } line_state_t;

    localparam line_state_t LineReset = '{len: 11'd0, f_begin: 1'b1, f_end: 1'b1,
                                          f_dash: 1'b1, f_b64: 1'b1};

    // Character of the BEGIN marker at a line position.
    function automatic logic [7:0] begin_char(logic [10:0] p);
        logic [7:0] r;
        r = 8'h00;
        if (p < 11'(BeginLen))
        begin
            r = BeginText[8*(BeginLen-1-int'(p)) +: 8];
        end
        return r;
    endfunction

    // Character of the END marker at a line position.
    function automatic logic [7:0] end_char(logic [10:0] p);
        logic [7:0] r;
        r = 8'h00;
        if (p < 11'(EndLen))
        begin
            r = EndText[8*(EndLen-1-int'(p)) +: 8];
        end
        return r;
    endfunction

    // Character of the private key pattern at a match position.
    function automatic logic [7:0] key_char(logic [3:0] p);
        logic [7:0] r;
        r = 8'h00;
        if (p < 4'(KeyLen))
        begin
            r = KeyText[8*(KeyLen-1-int'(p)) +: 8];
        end
        return r;
    endfunction

    // Base64 alphabet plus padding.
    function automatic logic is_b64(logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                         8'h2B, 8'h2F, 8'h3D};
    endfunction

    // Append one byte to the current line and narrow the match flags.
    function automatic line_state_t add_line_byte(line_state_t s, logic [7:0] c);
        line_state_t r;
        r = s;
        if (s.len >= 11'(BeginLen) || c != begin_char(s.len))
        begin
            r.f_begin = 1'b0;
        end
        if (s.len >= 11'(EndLen) || c != end_char(s.len))
        begin
            r.f_end = 1'b0;
        end
        if (s.len < 11'(DashLen) && c != DashByte)
        begin
            r.f_dash = 1'b0;
        end
        if (!is_b64(c))
        begin
            r.f_b64 = 1'b0;
        end
        if (s.len != LineSat)
        begin
            r.len = s.len + 11'd1;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/pbc_scan.sv
// ----------------------------------------------------------------------------
// PEM bundle scanner core
// Holds the per-bundle state and applies one text transaction per step;
// the status of a closing transaction is presented combinationally.
// ----------------------------------------------------------------------------
module pbc_scan
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       text_byte,
    input  logic             has_byte,
    input  logic             closing,
    input  pbc_pkg::cfg_t    cfg,
    output pbc_pkg::result_t result
);

    // Bundle state.
    logic [16:0]          byte_total_reg,  byte_total_next;
    logic                 bad_char_reg,    bad_char_next;
    logic [3:0]           key_pos_reg,     key_pos_next;
    logic                 key_seen_reg,    key_seen_next;
    logic                 inside_reg,      inside_next;
    logic [3:0]           cert_total_reg,  cert_total_next;
    logic                 body_seen_reg,   body_seen_next;
    pbc_pkg::line_state_t line_reg,        line_next;
    logic                 pending_cr_reg,  pending_cr_next;
    pbc_pkg::status_t     first_error_reg, first_error_next;

    // Line completion terms.
    logic                 do_finish;
    pbc_pkg::line_state_t done_line;
    logic                 is_begin;
    logic                 is_end;
    logic                 is_dash;

    // Per-transaction update, following the byte through the line logic.
    always_comb
    begin
        byte_total_next  = byte_total_reg;
        bad_char_next    = bad_char_reg;
        key_pos_next     = key_pos_reg;
        key_seen_next    = key_seen_reg;
        inside_next      = inside_reg;
        cert_total_next  = cert_total_reg;
        body_seen_next   = body_seen_reg;
        line_next        = line_reg;
        pending_cr_next  = pending_cr_reg;
        first_error_next = first_error_reg;
        do_finish        = 1'b0;

        if (has_byte)
        begin
            if (byte_total_reg != pbc_pkg::TotalSat)
            begin
                byte_total_next = byte_total_reg + 17'd1;
            end
            if (text_byte != pbc_pkg::LfByte && text_byte != pbc_pkg::CrByte &&
                (text_byte < pbc_pkg::SpaceByte || text_byte >= pbc_pkg::DelByte))
            begin
                bad_char_next = 1'b1;
            end

            // Private key pattern search over the raw bytes.
            if (key_pos_reg < 4'(pbc_pkg::KeyLen) &&
                text_byte == pbc_pkg::key_char(key_pos_reg))
            begin
                key_pos_next = key_pos_reg + 4'd1;
                if (key_pos_next == 4'(pbc_pkg::KeyLen))
                begin
                    key_seen_next = 1'b1;
                    key_pos_next  = 4'd0;
                end
            end
            else
            begin
                key_pos_next = (text_byte == pbc_pkg::KeyFirst) ? 4'd1 : 4'd0;
            end

            // A held CR becomes a line byte unless an LF follows it.
            if (text_byte == pbc_pkg::LfByte)
            begin
                do_finish = 1'b1;
            end
            else if (text_byte == pbc_pkg::CrByte)
            begin
                if (pending_cr_reg)
                begin
                    line_next = pbc_pkg::add_line_byte(line_next, pbc_pkg::CrByte);
                end
                pending_cr_next = 1'b1;
            end
            else
            begin
                if (pending_cr_reg)
                begin
                    line_next = pbc_pkg::add_line_byte(line_next, pbc_pkg::CrByte);
                end
                pending_cr_next = 1'b0;
                line_next = pbc_pkg::add_line_byte(line_next, text_byte);
            end
        end

        // An unterminated last line is checked at the close.
        if (closing && byte_total_next != 17'd0 &&
            (line_next.len != 11'd0 || pending_cr_next))
        begin
            do_finish = 1'b1;
        end

        done_line = line_next;
        is_begin  = done_line.f_begin && done_line.len == 11'(pbc_pkg::BeginLen);
        is_end    = done_line.f_end && done_line.len == 11'(pbc_pkg::EndLen);
        is_dash   = done_line.f_dash && done_line.len >= 11'(pbc_pkg::DashLen);

        // Classify the completed line; only the first error is kept.
        if (do_finish)
        begin
            line_next       = pbc_pkg::LineReset;
            pending_cr_next = 1'b0;
            if (first_error_next == pbc_pkg::STATUS_OK)
            begin
                if (done_line.len == 11'd0)
                begin
                    if (inside_next)
                    begin
                        first_error_next = pbc_pkg::STATUS_BAD_BASE64;
                    end
                end
                else if (!inside_next)
                begin
                    if (!is_begin)
                    begin
                        first_error_next = pbc_pkg::STATUS_NOT_CERT;
                    end
                    else if (cert_total_next == cfg.max_certs)
                    begin
                        first_error_next = pbc_pkg::STATUS_TOO_MANY;
                    end
                    else
                    begin
                        cert_total_next = cert_total_next + 4'd1;
                        inside_next     = 1'b1;
                        body_seen_next  = 1'b0;
                    end
                end
                else if (is_end)
                begin
                    if (!body_seen_next)
                    begin
                        first_error_next = pbc_pkg::STATUS_BAD_BASE64;
                    end
                    else
                    begin
                        inside_next = 1'b0;
                    end
                end
                else if (is_dash)
                begin
                    first_error_next = pbc_pkg::STATUS_NOT_CERT;
                end
                else if (done_line.len > {1'b0, cfg.max_line} || !done_line.f_b64)
                begin
                    first_error_next = pbc_pkg::STATUS_BAD_BASE64;
                end
                else
                begin
                    body_seen_next = 1'b1;
                end
            end
        end
    end

    // Final status in priority order.
    always_comb
    begin
        result.count = 4'd0;
        if (byte_total_next == 17'd0)
        begin
            result.status = pbc_pkg::STATUS_EMPTY;
        end
        else if (byte_total_next > {1'b0, cfg.max_bytes})
        begin
            result.status = pbc_pkg::STATUS_TOO_LONG;
        end
        else if (bad_char_next)
        begin
            result.status = pbc_pkg::STATUS_BAD_CHAR;
        end
        else if (key_seen_next)
        begin
            result.status = pbc_pkg::STATUS_PRIVATE_KEY;
        end
        else if (first_error_next != pbc_pkg::STATUS_OK)
        begin
            result.status = first_error_next;
        end
        else if (inside_next)
        begin
            result.status = pbc_pkg::STATUS_UNTERMINATED;
        end
        else if (cert_total_next == 4'd0)
        begin
            result.status = pbc_pkg::STATUS_NO_CERT;
        end
        else
        begin
            result.status = pbc_pkg::STATUS_OK;
            result.count  = cert_total_next;
        end
    end

    // State registers; a closing transaction returns them to the start state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_total_reg  <= 17'd0;
            bad_char_reg    <= 1'b0;
            key_pos_reg     <= 4'd0;
            key_seen_reg    <= 1'b0;
            inside_reg      <= 1'b0;
            cert_total_reg  <= 4'd0;
            body_seen_reg   <= 1'b0;
            line_reg        <= pbc_pkg::LineReset;
            pending_cr_reg  <= 1'b0;
            first_error_reg <= pbc_pkg::STATUS_OK;
        end
        else if (step)
        begin
            if (closing)
            begin
                byte_total_reg  <= 17'd0;
                bad_char_reg    <= 1'b0;
                key_pos_reg     <= 4'd0;
                key_seen_reg    <= 1'b0;
                inside_reg      <= 1'b0;
                cert_total_reg  <= 4'd0;
                body_seen_reg   <= 1'b0;
                line_reg        <= pbc_pkg::LineReset;
                pending_cr_reg  <= 1'b0;
                first_error_reg <= pbc_pkg::STATUS_OK;
            end
            else
            begin
                byte_total_reg  <= byte_total_next;
                bad_char_reg    <= bad_char_next;
                key_pos_reg     <= key_pos_next;
                key_seen_reg    <= key_seen_next;
                inside_reg      <= inside_next;
                cert_total_reg  <= cert_total_next;
                body_seen_reg   <= body_seen_next;
                line_reg        <= line_next;
                pending_cr_reg  <= pending_cr_next;
                first_error_reg <= first_error_next;
            end
        end
    end

endmodule

>>> hw/rtl/pem_bundle_checker.sv
// ----------------------------------------------------------------------------
// PEM bundle checker
// Checks a PEM certificate bundle streamed at most one byte per transaction and
// returns one status with the certificate count when the bundle closes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         text byte, byte-valid flag (tuser), bundle close (tlast)
//  m_*       out        status and certificate count, one per closed bundle
//  APB       in/out     max_bytes @0x0, max_certificates @0x4, max_line_bytes @0x8
//
//  One input transaction is taken per cycle while the input register can move
//  on. An accepted transaction is held in the input register and is scanned
//  at the edge that moves it on, which also loads the result register, so the
//  result of a closing transaction is registered and presented on m_*.
//  Reset clears the bundle state and loads the register defaults.
//  While a result waits on m_tready, ordinary bytes keep flowing; only a
//  closing transaction is held in the input register until the result is taken.
// ----------------------------------------------------------------------------
module pem_bundle_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // closing

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] status, [7:4] certificate_count

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    pbc_pkg::cfg_t      cfg_reg;
    pbc_pkg::reg_index_t reg_index;

    // Input register stage.
    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_has_reg;
    logic               in_close_reg;
    logic               advance;

    // Result register stage.
    logic               out_valid_reg;
    pbc_pkg::result_t   out_reg;
    pbc_pkg::result_t   scan_result;

    // Register access decode.
    assign pready    = 1'b1;
    assign reg_index = pbc_pkg::reg_index_t'(paddr[3:2]);

    always_comb
    begin
        case (reg_index)
            pbc_pkg::REG_MAX_BYTES: prdata = {16'd0, cfg_reg.max_bytes};
            pbc_pkg::REG_MAX_CERTS: prdata = {28'd0, cfg_reg.max_certs};
            pbc_pkg::REG_MAX_LINE:  prdata = {22'd0, cfg_reg.max_line};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_bytes <= pbc_pkg::MaxBytesReset;
            cfg_reg.max_certs <= pbc_pkg::MaxCertsReset;
            cfg_reg.max_line  <= pbc_pkg::MaxLineReset;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_index)
                pbc_pkg::REG_MAX_BYTES: cfg_reg.max_bytes <= pwdata[15:0];
                pbc_pkg::REG_MAX_CERTS: cfg_reg.max_certs <= pwdata[3:0];
                pbc_pkg::REG_MAX_LINE:  cfg_reg.max_line  <= pwdata[9:0];
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The held transaction moves on unless it closes a bundle and the
    // result slot is still occupied and not being taken.
    assign advance  = in_valid_reg && (!in_close_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_has_reg   <= s_tuser;
            in_close_reg <= s_tlast;
        end
    end

    // Bundle scanner.
    pbc_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .text_byte (in_byte_reg),
        .has_byte  (in_has_reg),
        .closing   (in_close_reg),
        .cfg       (cfg_reg),
        .result    (scan_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_close_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_close_reg)
        begin
            out_reg <= scan_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.count, out_reg.status};

endmodule
